FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define SKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define SKT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/skt_pkg.sv
package skt_pkg;

  // Default number of table entries.
  localparam int DEFAULT_DEPTH = 32;

  // Fixed field widths of the item channels.
  localparam int KEY_W = 32;
  localparam int POS_W = 5;
  localparam int TOTAL_W = 6;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_MISS  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_CHECK,
    S_MV_RD,
    S_MV_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [TOTAL_W-1:0] entry_total;
  } out_item_t;

endpackage

FILE: rtl/sorted_key_table.sv
// Each search step and each entry move waits on the registered read of the key memory.
// Throughput: one command at a time; the next is accepted once the result is registered.
// Reset: entry count cleared; key memory contents stay undefined, with no clearing pass.
// Only entries below the count are ever read, and all of those have been written.
`include "assert_macros.svh"

module sorted_key_table #(
  parameter int TABLE_DEPTH = skt_pkg::DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  skt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output skt_pkg::out_item_t out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // Key memory, one write and one registered read per cycle.
  logic [skt_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [skt_pkg::KEY_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [IDX_W-1:0]          mem_raddr;
  logic [skt_pkg::KEY_W-1:0] rd_data_r;

  skt_pkg::state_t          state_r, state_nxt;
  skt_pkg::cmd_t            cmd_r, cmd_nxt;
  logic [skt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [CNT_W-1:0]         mid_r, mid_nxt;
  logic [CNT_W-1:0]         mv_ptr_r, mv_ptr_nxt;
  skt_pkg::status_t         res_status_r, res_status_nxt;
  logic [CNT_W-1:0]         res_pos_r, res_pos_nxt;
  logic                     out_valid_r, out_valid_nxt;
  skt_pkg::out_item_t       out_data_r, out_data_nxt;

  logic             accept;
  logic             early_done;
  logic [CNT_W-1:0] mid;
  logic             search_end;
  logic             probe;
  logic             resolve;
  logic             hit;
  logic             move_start;
  logic             is_insert;
  logic             mv_last;
  logic [CNT_W-1:0] mv_next_idx;
  logic             out_load;

  // Decisions shared by the next-state and datapath logic.
  always_comb begin
    accept      = (state_r == skt_pkg::S_IDLE) && in_valid;
    early_done  = (in_data.cmd == skt_pkg::CMD_NOP) ||
                  ((in_data.cmd == skt_pkg::CMD_INSERT) && (cnt_r == FULL_CNT)) ||
                  ((in_data.cmd == skt_pkg::CMD_REMOVE) && (cnt_r == '0));
    mid         = lo_r + ((hi_r - lo_r) >> 1);
    search_end  = (state_r == skt_pkg::S_SEARCH) && (lo_r == hi_r);
    probe       = search_end && (lo_r < cnt_r);
    resolve     = (search_end && !probe) || (state_r == skt_pkg::S_CHECK);
    hit         = (state_r == skt_pkg::S_CHECK) && (rd_data_r == key_r);
    is_insert   = (cmd_r == skt_pkg::CMD_INSERT);
    move_start  = resolve && ((is_insert && !hit) ||
                              ((cmd_r == skt_pkg::CMD_REMOVE) && hit));
    mv_last     = is_insert ? (mv_ptr_r == lo_r) : (mv_ptr_r == (cnt_r - ONE_CNT));
    // Entry that the move copies from next: below for insert, above for remove.
    mv_next_idx = is_insert ? (mv_ptr_r - ONE_CNT) : (mv_ptr_r + ONE_CNT);
    out_load    = (state_r == skt_pkg::S_DONE) && (!out_valid_r || !out_stall);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = early_done ? skt_pkg::S_DONE : skt_pkg::S_SEARCH;
        end
      end
      skt_pkg::S_SEARCH: begin
        if (!search_end) begin
          state_nxt = skt_pkg::S_CMP;
        end else if (probe) begin
          state_nxt = skt_pkg::S_CHECK;
        end else begin
          state_nxt = move_start ? skt_pkg::S_MV_RD : skt_pkg::S_DONE;
        end
      end
      skt_pkg::S_CMP:   state_nxt = skt_pkg::S_SEARCH;
      skt_pkg::S_CHECK: state_nxt = move_start ? skt_pkg::S_MV_RD : skt_pkg::S_DONE;
      skt_pkg::S_MV_RD: state_nxt = mv_last ? skt_pkg::S_DONE : skt_pkg::S_MV_WR;
      skt_pkg::S_MV_WR: state_nxt = skt_pkg::S_MV_RD;
      skt_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = skt_pkg::S_IDLE;
        end
      end
      default: state_nxt = skt_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result register.
  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    mv_ptr_nxt     = mv_ptr_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_waddr      = mv_ptr_r[IDX_W-1:0];
    mem_wdata      = rd_data_r;
    mem_re         = 1'b0;
    mem_raddr      = mid[IDX_W-1:0];

    unique case (state_r)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_data.cmd;
          key_nxt     = in_data.key;
          lo_nxt      = '0;
          hi_nxt      = cnt_r;
          res_pos_nxt = '0;
          if (in_data.cmd == skt_pkg::CMD_NOP) begin
            res_status_nxt = skt_pkg::ST_OK;
          end else if (in_data.cmd == skt_pkg::CMD_INSERT) begin
            res_status_nxt = skt_pkg::ST_FULL;
          end else begin
            res_status_nxt = skt_pkg::ST_EMPTY;
          end
        end
      end
      skt_pkg::S_SEARCH: begin
        // Probe the midpoint, or the final slot to test for a match.
        if (!search_end) begin
          mem_re  = 1'b1;
          mid_nxt = mid;
        end else if (probe) begin
          mem_re    = 1'b1;
          mem_raddr = lo_r[IDX_W-1:0];
        end
      end
      skt_pkg::S_CMP: begin
        if (rd_data_r < key_r) begin
          lo_nxt = mid_r + ONE_CNT;
        end else begin
          hi_nxt = mid_r;
        end
      end
      skt_pkg::S_MV_RD: begin
        if (mv_last) begin
          res_status_nxt = skt_pkg::ST_OK;
          res_pos_nxt    = lo_r;
          if (is_insert) begin
            mem_we    = 1'b1;
            mem_waddr = lo_r[IDX_W-1:0];
            mem_wdata = key_r;
            cnt_nxt   = cnt_r + ONE_CNT;
          end else begin
            cnt_nxt = cnt_r - ONE_CNT;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = mv_next_idx[IDX_W-1:0];
        end
      end
      skt_pkg::S_MV_WR: begin
        mem_we     = 1'b1;
        mv_ptr_nxt = mv_next_idx;
      end
      skt_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.position    = skt_pkg::POS_W'(res_pos_r);
          out_data_nxt.entry_total = skt_pkg::TOTAL_W'(cnt_r);
        end
      end
      default: begin
      end
    endcase

    // Outcome of the search once the slot is known.
    if (resolve) begin
      if (move_start) begin
        mv_ptr_nxt = is_insert ? cnt_r : lo_r;
      end else if (hit) begin
        res_status_nxt = is_insert ? skt_pkg::ST_DUP : skt_pkg::ST_OK;
        res_pos_nxt    = lo_r;
      end else begin
        res_status_nxt = skt_pkg::ST_MISS;
        res_pos_nxt    = '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    mv_ptr_r     <= mv_ptr_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Key memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= key_mem[mem_raddr];
    end
  end

  assign in_stall  = (state_r != skt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the capacity.
  `SKT_ASSERT(a_cnt_bound, cnt_r <= FULL_CNT, "entry count above capacity")
  // The count changes only at the end of an entry move.
  `SKT_ASSERT_IMPL(a_cnt_hold, state_r != skt_pkg::S_MV_RD, ##1 $stable(cnt_r), "count changed outside move")
  // Search bounds stay ordered.
  `SKT_ASSERT_IMPL(a_bounds, state_r == skt_pkg::S_SEARCH, lo_r <= hi_r && hi_r <= cnt_r, "search bounds out of order")
  // A new result comes only from the finishing state.
  `SKT_ASSERT_IMPL(a_res_src, $rose(out_valid_r), $past(state_r) == skt_pkg::S_DONE, "result loaded outside finish")

endmodule
